FILE: sv/dspc_pkg.sv
// ----------------------------------------------------------------------------
// Delta sample playback channel package
// Command codes, register indexes, field widths and address constants that
// the channel unit shares.
// ----------------------------------------------------------------------------
package dspc_pkg;

   // Field widths.
   localparam int CommandWidth = 2;
   localparam int ValueWidth   = 8;
   localparam int LevelWidth   = 7;
   localparam int AddrWidth    = 16;
   localparam int TimerWidth   = 10;
   localparam int CountWidth   = 12;
   localparam int BitsWidth    = 4;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 10;

   // Input beat commands.
   typedef enum logic [CommandWidth-1:0] {
      CMD_TICK       = 2'd0,
      CMD_ENABLE     = 2'd1,
      CMD_LOAD_LEVEL = 2'd2,
      CMD_MEM_BYTE   = 2'd3
   } command_type;

   // Configuration register indexes.
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_RATE_PERIOD = 2'd0,
      CSR_LOOP_ENABLE = 2'd1,
      CSR_START_ADDR  = 2'd2,
      CSR_LENGTH      = 2'd3
   } csr_index_type;

   // Reset values and constants.
   localparam logic [TimerWidth-1:0] RatePeriodReset = 10'd428;
   localparam logic [AddrWidth-1:0]  SampleBase      = 16'hC000;
   localparam logic [AddrWidth-1:0]  WrapAddr        = 16'h8000;
   localparam logic [LevelWidth-1:0] LevelHighLimit  = 7'd125;
   localparam logic [LevelWidth-1:0] LevelStep       = 7'd2;
   localparam logic [BitsWidth-1:0]  BitsPerByte     = 4'd8;

   // Sample start address: base plus 64 times the register.
   function automatic logic [AddrWidth-1:0] start_address(input logic [7:0] start_byte);
      start_address = SampleBase + {2'b00, start_byte, 6'b000000};
   endfunction

   // Sample length: 16 times the register plus one.
   function automatic logic [CountWidth-1:0] sample_byte_count(input logic [7:0] length_byte);
      sample_byte_count = {length_byte, 4'b0000} + 12'd1;
   endfunction

endpackage

FILE: sv/delta_sample_playback_channel_unit.sv
// ----------------------------------------------------------------------------
// Delta sample playback channel unit
// Delta-modulation sample player with timer, shifter, one-byte sample
// buffer and memory reader, one result beat per input beat.
// ----------------------------------------------------------------------------
// The unit takes one input beat per clock cycle while the result side is not
// stalled, and returns exactly one result beat for each. An accepted beat
// waits in the input register until the result register is free; its timer,
// level, shifter and fetch update is then done in a single pass of logic into
// the result register, from which it is taken when the result side is ready.
// The input register and the result register are separate, so a new beat can
// be accepted while a finished result still waits, if the input register is empty.
// Configuration writes take effect at once and are expected only while no beat
// is in flight.
module delta_sample_playback_channel_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input channel.
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dspc_pkg::CommandWidth-1:0]    req_command,
   input  logic [dspc_pkg::ValueWidth-1:0]      req_value,
   // Result channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dspc_pkg::LevelWidth-1:0]      rsp_dac_level,
   output logic                                 rsp_fetch_request,
   output logic [dspc_pkg::AddrWidth-1:0]       rsp_fetch_addr,
   output logic                                 rsp_busy_res,
   // Configuration port.
   input  logic                                 csr_write_enable,
   input  logic [dspc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [dspc_pkg::CsrDataWidth-1:0]    csr_data
);
   import dspc_pkg::*;

   // Configuration registers.
   logic [TimerWidth-1:0] rate_period_ff;
   logic                  loop_enable_ff;
   logic [7:0]            start_addr_byte_ff;
   logic [7:0]            length_byte_ff;

   // Input register.
   logic                  in_valid_ff;
   command_type           in_command_ff;
   logic [ValueWidth-1:0] in_value_ff;

   // Channel state and its next values.
   logic [TimerWidth-1:0] timer_count_ff,     timer_count_in;
   logic [7:0]            shifter_ff,         shifter_in;
   logic [BitsWidth-1:0]  bits_left_ff,       bits_left_in;
   logic                  silent_flag_ff,     silent_flag_in;
   logic [LevelWidth-1:0] level_ff,           level_in;
   logic [7:0]            sample_buffer_ff,   sample_buffer_in;
   logic                  buffer_full_ff,     buffer_full_in;
   logic                  fetch_pending_ff,   fetch_pending_in;
   logic [AddrWidth-1:0]  current_address_ff, current_address_in;
   logic [CountWidth-1:0] bytes_left_ff,      bytes_left_in;

   // Result register and its next values.
   logic                  rsp_valid_ff;
   logic [LevelWidth-1:0] rsp_dac_level_ff;
   logic                  rsp_fetch_request_ff, rsp_fetch_request_in;
   logic [AddrWidth-1:0]  rsp_fetch_addr_ff,    rsp_fetch_addr_in;
   logic                  rsp_busy_res_ff;

   logic                  step;
   logic [AddrWidth-1:0]  addr_next;
   logic [CountWidth-1:0] bytes_after_cmd;
   logic                  buffer_after_cmd;
   logic                  pending_after_cmd;

   // A beat in the input register is processed when the result register is free.
   assign step      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_period_ff     <= RatePeriodReset;
         loop_enable_ff     <= 1'b0;
         start_addr_byte_ff <= '0;
         length_byte_ff     <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_RATE_PERIOD: rate_period_ff     <= csr_data;
            CSR_LOOP_ENABLE: loop_enable_ff     <= csr_data[0];
            CSR_START_ADDR:  start_addr_byte_ff <= csr_data[7:0];
            CSR_LENGTH:      length_byte_ff     <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_command_ff <= command_type'(req_command);
         in_value_ff   <= req_value;
      end
   end

   // Command handling and the memory reader, one pass per beat.
   always_comb begin
      timer_count_in       = timer_count_ff;
      shifter_in           = shifter_ff;
      bits_left_in         = bits_left_ff;
      silent_flag_in       = silent_flag_ff;
      level_in             = level_ff;
      sample_buffer_in     = sample_buffer_ff;
      buffer_full_in       = buffer_full_ff;
      fetch_pending_in     = fetch_pending_ff;
      current_address_in   = current_address_ff;
      bytes_left_in        = bytes_left_ff;
      rsp_fetch_request_in = 1'b0;
      rsp_fetch_addr_in    = '0;
      addr_next            = current_address_ff + 16'd1;

      unique case (in_command_ff)
         CMD_TICK: begin
            if (timer_count_ff != '0) begin
               timer_count_in = timer_count_ff - 10'd1;
            end else begin
               // Timer expiry: output one bit and advance the shifter.
               timer_count_in = rate_period_ff;
               if (!silent_flag_ff) begin
                  if (shifter_ff[0]) begin
                     if (level_ff <= LevelHighLimit) level_in = level_ff + LevelStep;
                  end else begin
                     if (level_ff >= LevelStep) level_in = level_ff - LevelStep;
                  end
               end
               shifter_in = {1'b0, shifter_ff[7:1]};
               if (bits_left_ff <= 4'd1) begin
                  bits_left_in = BitsPerByte;
                  if (buffer_full_ff) begin
                     shifter_in     = sample_buffer_ff;
                     buffer_full_in = 1'b0;
                     silent_flag_in = 1'b0;
                  end else begin
                     silent_flag_in = 1'b1;
                  end
               end else begin
                  bits_left_in = bits_left_ff - 4'd1;
               end
            end
         end
         CMD_ENABLE: begin
            if (in_value_ff[0]) begin
               if (bytes_left_ff == '0) begin
                  current_address_in = start_address(start_addr_byte_ff);
                  bytes_left_in      = sample_byte_count(length_byte_ff);
               end
            end else begin
               bytes_left_in = '0;
            end
         end
         CMD_LOAD_LEVEL: begin
            level_in = in_value_ff[LevelWidth-1:0];
         end
         CMD_MEM_BYTE: begin
            if (fetch_pending_ff) begin
               sample_buffer_in = in_value_ff;
               buffer_full_in   = 1'b1;
               fetch_pending_in = 1'b0;
            end
         end
         default: ;
      endcase

      bytes_after_cmd   = bytes_left_in;
      buffer_after_cmd  = buffer_full_in;
      pending_after_cmd = fetch_pending_in;
      addr_next         = current_address_in + 16'd1;

      // Issue a fetch when the buffer is empty, no fetch is pending and bytes remain.
      if (bytes_after_cmd != '0 && !buffer_after_cmd && !pending_after_cmd) begin
         rsp_fetch_request_in = 1'b1;
         rsp_fetch_addr_in    = current_address_in;
         fetch_pending_in     = 1'b1;
         current_address_in   = (addr_next == '0) ? WrapAddr : addr_next;
         bytes_left_in        = bytes_after_cmd - 12'd1;
         if (bytes_left_in == '0 && loop_enable_ff) begin
            current_address_in = start_address(start_addr_byte_ff);
            bytes_left_in      = sample_byte_count(length_byte_ff);
         end
      end
   end

   // Channel state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_count_ff     <= '0;
         shifter_ff         <= '0;
         bits_left_ff       <= BitsPerByte;
         silent_flag_ff     <= 1'b1;
         level_ff           <= '0;
         buffer_full_ff     <= 1'b0;
         fetch_pending_ff   <= 1'b0;
         current_address_ff <= '0;
         bytes_left_ff      <= '0;
      end else if (step) begin
         timer_count_ff     <= timer_count_in;
         shifter_ff         <= shifter_in;
         bits_left_ff       <= bits_left_in;
         silent_flag_ff     <= silent_flag_in;
         level_ff           <= level_in;
         buffer_full_ff     <= buffer_full_in;
         fetch_pending_ff   <= fetch_pending_in;
         current_address_ff <= current_address_in;
         bytes_left_ff      <= bytes_left_in;
      end
   end

   // The sample buffer holds data only, no reset.
   always_ff @(posedge clock) begin
      if (step) begin
         sample_buffer_ff <= sample_buffer_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_dac_level_ff     <= level_in;
         rsp_fetch_request_ff <= rsp_fetch_request_in;
         rsp_fetch_addr_ff    <= rsp_fetch_addr_in;
         rsp_busy_res_ff      <= (bytes_left_in != '0);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dac_level     = rsp_dac_level_ff;
   assign rsp_fetch_request = rsp_fetch_request_ff;
   assign rsp_fetch_addr    = rsp_fetch_addr_ff;
   assign rsp_busy_res      = rsp_busy_res_ff;

   // The buffer is only filled by answering an outstanding fetch.
   a_pending_buffer_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(fetch_pending_ff && buffer_full_ff))
      else $error("fetch pending while sample buffer is full");

   // The shifter bit counter stays between one and eight.
   a_bits_left_range: assert property (@(posedge clock) disable iff (reset)
      (bits_left_ff != '0) && (bits_left_ff <= BitsPerByte))
      else $error("bits_left out of range");

   // A result without a fetch carries a zero address.
   a_idle_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fetch_request |-> rsp_fetch_addr == '0)
      else $error("fetch address set without a fetch request");

   // Issuing a fetch leaves a request outstanding.
   a_fetch_sets_pending: assert property (@(posedge clock) disable iff (reset)
      step && rsp_fetch_request_in |=> fetch_pending_ff)
      else $error("fetch issued but not recorded as pending");

   // A processed beat always yields a result beat.
   a_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("processed beat produced no result");

endmodule
